### rtl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by every module of the block.
package lpht_pkg;

    localparam int KEY_W           = 31;
    localparam int SIZE_W          = 11;
    localparam int SLOT_W          = 10;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int SIZE_RESET      = 1024;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } resp_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic prb_start;
        logic probe;
        logic out_load;
        logic clr_step;
    } lpht_cmd_t;

    typedef struct packed {
        logic cfg_wr;
        logic prb_fin;
        logic out_free;
        logic clr_last;
    } lpht_sts_t;

endpackage

### rtl/lpht_ctrl.sv
// Sequencer for the hash table: clear sweep, modulo steps, probe walk, response.
// Depends on lpht_pkg.
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lpht_sts_t sts,
    output lpht_cmd_t cmd
);

    localparam int DIV_CW = $clog2(KEY_W);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PSTART,
        S_PROBE,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic                ready_reg, ready_next;
    logic [DIV_CW-1:0]   div_cnt_reg, div_cnt_next;

    assign s_ready = ready_reg;

    always_comb begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        div_cnt_next = div_cnt_reg;
        if (sts.cfg_wr) begin
            state_next = S_CLEAR;
            ready_next = 1'b0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    if (sts.clr_last) begin
                        state_next = S_IDLE;
                        ready_next = 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        state_next   = S_DIV;
                        ready_next   = 1'b0;
                        div_cnt_next = '0;
                    end
                end
                S_DIV: begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CW'(KEY_W - 1)) begin
                        state_next = S_PSTART;
                    end
                end
                S_PSTART: begin
                    state_next = S_PROBE;
                end
                S_PROBE: begin
                    if (sts.prb_fin) begin
                        state_next = S_RESP;
                    end
                end
                S_RESP: begin
                    if (sts.out_free) begin
                        state_next = S_IDLE;
                        ready_next = 1'b1;
                    end
                end
                default: begin
                    state_next = S_CLEAR;
                    ready_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            ready_reg   <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ready_reg   <= ready_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.clr_step  = (state_reg == S_CLEAR);
        cmd.load      = (state_reg == S_IDLE) && s_valid;
        cmd.div_step  = (state_reg == S_DIV);
        cmd.prb_start = (state_reg == S_PSTART);
        cmd.probe     = (state_reg == S_PROBE);
        cmd.out_load  = (state_reg == S_RESP) && sts.out_free;
    end

endmodule

### rtl/lpht_dp.sv
// Datapath: size register, bit-serial modulo, slot memory, probe logic, output register.
// Depends on lpht_pkg; driven by lpht_ctrl commands.
module lpht_dp
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output resp_t             m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  lpht_cmd_t         cmd,
    output lpht_sts_t         sts
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW    = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (int'(v) > TABLE_DEPTH) begin
            r = SIZE_W'(TABLE_DEPTH);
        end else begin
            r = v;
        end
        return r;
    endfunction

    localparam logic [SIZE_W-1:0] SIZE_RST = clamp_size(SIZE_W'(SIZE_RESET));

    typedef struct packed {
        logic [1:0]       mark;
        logic [KEY_W-1:0] key;
    } slot_t;

    slot_t             mem [TABLE_DEPTH];
    slot_t             rdata_reg;

    logic [SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic [1:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  kshift_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [SIZE_W-1:0] cnt_reg;
    resp_t             res_reg;
    logic              m_valid_reg;
    resp_t             m_data_reg;

    logic              cfg_wr;
    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W-1:0] rem_next;
    logic [IDX_W-1:0]  home;
    logic [PW-1:0]     cur_inc;
    logic [IDX_W-1:0]  pos_next;
    logic [IDX_W-1:0]  raddr;
    logic              last;
    logic              fin;
    logic              wr;
    logic [1:0]        wmark;
    logic [1:0]        res_status;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    slot_t             wdata;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // restoring remainder, one key bit per step
    assign rem_sh   = {rem_reg, kshift_reg[KEY_W-1]};
    assign rem_next = (rem_sh >= {1'b0, size_reg}) ? SIZE_W'(rem_sh - {1'b0, size_reg})
                                                   : SIZE_W'(rem_sh);
    assign home     = IDX_W'(rem_reg);

    assign cur_inc  = PW'(cur_reg) + PW'(1);
    assign pos_next = (cur_inc == PW'(size_reg)) ? '0 : IDX_W'(cur_inc);
    assign raddr    = cmd.prb_start ? home : pos_next;
    assign last     = (cnt_reg == size_reg);

    always_comb begin
        fin        = 1'b0;
        wr         = 1'b0;
        wmark      = MARK_USED;
        res_status = ST_MISS;
        case (cmd_reg) inside
            CMD_INSERT: begin
                if (rdata_reg.mark != MARK_USED) begin
                    fin        = 1'b1;
                    wr         = 1'b1;
                    res_status = ST_DONE;
                end else if (last) begin
                    fin        = 1'b1;
                    res_status = ST_FULL;
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                if (rdata_reg.mark == MARK_EMPTY) begin
                    fin = 1'b1;
                end else if (rdata_reg.mark == MARK_USED && rdata_reg.key == key_reg) begin
                    fin        = 1'b1;
                    res_status = ST_DONE;
                    wr         = (cmd_reg == CMD_DELETE);
                    wmark      = MARK_TOMB;
                end else if (last) begin
                    fin = 1'b1;
                end
            end
            default: begin
                fin = 1'b1;
            end
        endcase
    end

    assign we    = cmd.clr_step | (cmd.probe & fin & wr);
    assign waddr = cmd.clr_step ? clr_addr_reg : cur_reg;
    assign wdata = cmd.clr_step ? slot_t'{mark: MARK_EMPTY, key: '0}
                                : slot_t'{mark: wmark, key: key_reg};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= SIZE_RST;
            clr_addr_reg <= '0;
        end else if (cfg_wr) begin
            size_reg     <= clamp_size(cfg_data);
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= s_data.cmd;
            key_reg    <= s_data.key;
            kshift_reg <= s_data.key;
            rem_reg    <= '0;
        end else if (cmd.div_step) begin
            kshift_reg <= kshift_reg << 1;
            rem_reg    <= rem_next;
        end
        if (cmd.prb_start) begin
            cur_reg <= home;
            cnt_reg <= SIZE_W'(1);
        end else if (cmd.probe) begin
            if (fin) begin
                res_reg.status     <= res_status;
                res_reg.slot_index <= (res_status == ST_DONE) ? SLOT_W'(cur_reg) : '0;
            end else begin
                cur_reg <= pos_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.cfg_wr   = cfg_wr;
    assign sts.prb_fin  = fin;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.clr_last = (clr_addr_reg == IDX_W'(TABLE_DEPTH - 1));

endmodule

### rtl/linear_probe_hash_table.sv
// Top level of the linear probing hash table: sequencer plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
//   channel  | dir | payload          | handshake
//   s_       | in  | req_t  cmd, key  | s_valid / s_ready
//   m_       | out | resp_t status,   | m_valid / m_ready
//            |     |  slot_index      |
//   cfg_     | in  | table_size       | cfg_valid / cfg_ready (always ready)
//
// A request first forms the remainder one key bit per cycle; then the probe
// walk reads one slot a cycle (1 to table_size probes) from the slot memory,
// which has one write port and one read port.
// After reset and after every table_size write a clearing pass over all
// TABLE_DEPTH slots runs with s_ready low. The result waits in an output
// register; a stalled m_ready holds the block only once the next result is ready.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output resp_t             m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    lpht_cmd_t cmd;
    lpht_sts_t sts;

    lpht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lpht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### rtl/lpht_checker.sv
// Port-level checks for linear_probe_hash_table, attached by bind.
// Depends on lpht_pkg.
module lpht_checker
    import lpht_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input resp_t             m_data,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response dropped or changed while stalled");

    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_DONE |-> m_data.slot_index == '0)
        else $error("non-zero slot index on miss or full");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_DONE || m_data.status == ST_MISS ||
                     m_data.status == ST_FULL))
        else $error("illegal status code");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in flight");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("request channel open during clearing pass");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
